/* hw/rtl/crse_pkg.sv */
// ----------------------------------------------------------------------------
// crse_pkg: shared types and constants for the stroke extruder
// Coordinate, coefficient and accumulator widths, register indexes, the
// command passed from the front end to the sample engine, and saturation.
// ----------------------------------------------------------------------------
package crse_pkg;

	localparam int COORD_W   = 16;
	localparam int T_FRAC    = 16;
	localparam int STEP_W    = 17;
	localparam int THICK_W   = 12;
	localparam int COEF_W    = COORD_W + 4;
	localparam int ACC_W     = COEF_W + T_FRAC + 6;
	localparam int MAX_SEG   = 33;
	localparam int SEG_CNT_W = 6;
	localparam int KW        = 12;
	localparam int KBIT_W    = 4;
	localparam int MAG_W     = COORD_W + 1;
	localparam int L2_W      = 2 * MAG_W + 1;
	localparam int Q_W       = MAG_W + THICK_W;
	localparam int Q2_W      = 2 * Q_W;
	localparam int P_W       = 64;
	localparam int SAT_W     = 26;
	localparam int CFG_IDX_W = 8;
	localparam int DATA_W    = 4 * COORD_W;

	localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_THICKNESS = CFG_IDX_W'(1);

	localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'(6554);
	localparam logic [THICK_W-1:0] THICK_RESET = THICK_W'(16);
	localparam logic [THICK_W-1:0] THICK_MIN   = THICK_W'(16);

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [COEF_W-1:0]  coef_t;

	// One accepted point as seen by the sample engine; lane 0 is x, lane 1 is y.
	typedef struct packed {
		logic            seg;
		logic            last;
		coef_t [1:0]     ca;
		coef_t [1:0]     cb;
		coef_t [1:0]     cc;
		coef_t [1:0]     cd;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic pend_v;
	} back_stat_t;

	// Clamp a wide signed value to the coordinate range.
	function automatic coord_t sat_coord(input logic signed [SAT_W-1:0] v);
		logic signed [SAT_W-1:0] hi;
		logic signed [SAT_W-1:0] lo;
		hi = $signed({{(SAT_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}});
		lo = $signed({{(SAT_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}});
		if (v > hi) begin
			return {1'b0, {(COORD_W-1){1'b1}}};
		end else if (v < lo) begin
			return {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			return v[COORD_W-1:0];
		end
	endfunction

endpackage

/* hw/rtl/catmull_rom_stroke_extruder.sv */
// A vertex pair is finished by the search after the sample that follows it, then
// waits in a one-pair hold until the next pair is complete or its point ends. A
// sample that only fills the history runs just the Horner states; an emitted pair
// adds the offset search at one bit per cycle, up to 33 samples per point, and the
// closing pair of a spline runs the search too; output stalls hold the engine.
// Reset: arst_n clears the window, queue, sequencer and output valid at once.
// ----------------------------------------------------------------------------
// catmull_rom_stroke_extruder: top level
// Configuration registers, point front end, command queue and sample engine.
// ----------------------------------------------------------------------------
module catmull_rom_stroke_extruder import crse_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [2*COORD_W-1:0] s_axis_tdata,  // point_x, point_y
	input  logic                 s_axis_tlast,  // last_point
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [DATA_W-1:0]    m_axis_tdata,  // left_x, left_y, right_x, right_y
	output logic                 m_axis_tlast,  // run_last
	output logic [0:0]           m_axis_tuser,  // spline_last
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [STEP_W-1:0]    cfg_data
);

	logic [STEP_W-1:0]  step_q;
	logic [THICK_W-1:0] thick_q;
	logic               q_full;
	logic               q_empty;
	logic               q_push;
	logic               q_pop;
	cmd_t               wr_cmd;
	cmd_t               rd_cmd;
	back_stat_t         stat;
	logic               user_bit;

	assign cfg_ready       = 1'b1;
	assign m_axis_tuser[0] = user_bit;

	// Configuration registers; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= STEP_RESET;
			thick_q <= THICK_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_STEP_SIZE) begin
				step_q <= cfg_data;
			end else if (cfg_index == REG_THICKNESS) begin
				thick_q <= cfg_data[THICK_W-1:0];
			end
		end
	end

	crse_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.px       (s_axis_tdata[COORD_W-1:0]),
		.py       (s_axis_tdata[2*COORD_W-1:COORD_W]),
		.lastp    (s_axis_tlast),
		.step_nz  (step_q != '0),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (wr_cmd)
	);

	crse_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_cmd (wr_cmd),
		.pop    (q_pop),
		.rd_cmd (rd_cmd),
		.full   (q_full),
		.empty  (q_empty)
	);

	crse_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_cmd     (rd_cmd),
		.q_pop     (q_pop),
		.step      (step_q),
		.thick     (thick_q),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.out_user  (user_bit),
		.stat      (stat)
	);

`ifndef SYNTH
	// The final pair of a spline always closes the run of its point.
	a_spline_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && user_bit) |-> m_axis_tlast)
		else $error("spline_last without run_last");

	// An idle engine holds no undelivered pair.
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		!stat.busy |-> !stat.pend_v)
		else $error("pending pair left while engine idle");

	// The engine never pops an empty queue.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("command queue underflow");
`endif

endmodule

/* hw/rtl/crse_front.sv */
// ----------------------------------------------------------------------------
// crse_front: control point window and segment classification
// Keeps the last three points, decides whether a new point closes a segment
// and forms the cubic coefficients for both axes.
// ----------------------------------------------------------------------------
module crse_front import crse_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  coord_t px,
	input  coord_t py,
	input  logic   lastp,
	input  logic   step_nz,
	input  logic   q_full,
	output logic   q_push,
	output cmd_t   q_cmd
);

	coord_t     win_x_q [3];
	coord_t     win_y_q [3];
	logic [1:0] seen_q;
	coef_t      p0 [2];
	coef_t      p1 [2];
	coef_t      p2 [2];
	coef_t      p3 [2];

	assign in_ready = !q_full;
	assign q_push   = in_valid && in_ready;

	// Coefficients of the uniform Catmull-Rom cubic, times two.
	always_comb begin
		p0[0] = COEF_W'(win_x_q[0]);
		p1[0] = COEF_W'(win_x_q[1]);
		p2[0] = COEF_W'(win_x_q[2]);
		p3[0] = COEF_W'(px);
		p0[1] = COEF_W'(win_y_q[0]);
		p1[1] = COEF_W'(win_y_q[1]);
		p2[1] = COEF_W'(win_y_q[2]);
		p3[1] = COEF_W'(py);
		q_cmd.seg  = (seen_q == 2'd3) && step_nz;
		q_cmd.last = lastp;
		for (int l = 0; l < 2; l++) begin
			q_cmd.ca[l] = p1[l] <<< 1;
			q_cmd.cb[l] = p2[l] - p0[l];
			q_cmd.cc[l] = (p0[l] <<< 1) - ((p1[l] <<< 2) + p1[l]) + (p2[l] <<< 2) - p3[l];
			q_cmd.cd[l] = ((p1[l] <<< 1) + p1[l]) - ((p2[l] <<< 1) + p2[l]) + p3[l] - p0[l];
		end
	end

	// Window shift; the last point of a spline clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 2'd0;
			for (int i = 0; i < 3; i++) begin
				win_x_q[i] <= '0;
				win_y_q[i] <= '0;
			end
		end else if (q_push) begin
			if (lastp) begin
				seen_q <= 2'd0;
				for (int i = 0; i < 3; i++) begin
					win_x_q[i] <= '0;
					win_y_q[i] <= '0;
				end
			end else begin
				win_x_q[0] <= win_x_q[1];
				win_x_q[1] <= win_x_q[2];
				win_x_q[2] <= px;
				win_y_q[0] <= win_y_q[1];
				win_y_q[1] <= win_y_q[2];
				win_y_q[2] <= py;
				if (seen_q != 2'd3) begin
					seen_q <= seen_q + 2'd1;
				end
			end
		end
	end

endmodule

/* hw/rtl/crse_cmdq.sv */
// ----------------------------------------------------------------------------
// crse_cmdq: two-entry command queue
// Decouples the point front end from the sample engine.
// ----------------------------------------------------------------------------
module crse_cmdq import crse_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wr_cmd,
	input  logic pop,
	output cmd_t rd_cmd,
	output logic full,
	output logic empty
);

	cmd_t       mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full   = (cnt_q == 2'd2);
	assign empty  = (cnt_q == 2'd0);
	assign rd_cmd = mem_q[rp_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

/* hw/rtl/crse_back.sv */
// ----------------------------------------------------------------------------
// crse_back: sample engine
// Steps t over a segment, evaluates the cubic by Horner's rule, keeps the
// sample history, finds the normal offset by a bit-per-cycle search and
// delivers vertex pairs through a held result and an output register.
// ----------------------------------------------------------------------------
module crse_back import crse_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  cmd_t                q_cmd,
	output logic                q_pop,
	input  logic [STEP_W-1:0]   step,
	input  logic [THICK_W-1:0]  thick,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [DATA_W-1:0]   out_data,
	output logic                out_last,
	output logic                out_user,
	output back_stat_t          stat
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_C0    = 4'd1;
	localparam logic [3:0] ST_C1    = 4'd2;
	localparam logic [3:0] ST_C2    = 4'd3;
	localparam logic [3:0] ST_C3    = 4'd4;
	localparam logic [3:0] ST_ADV   = 4'd5;
	localparam logic [3:0] ST_TAIL  = 4'd6;
	localparam logic [3:0] ST_SQ    = 4'd7;
	localparam logic [3:0] ST_SQ2   = 4'd8;
	localparam logic [3:0] ST_ITER  = 4'd9;
	localparam logic [3:0] ST_OUTC  = 4'd10;
	localparam logic [3:0] ST_PUT   = 4'd11;
	localparam logic [3:0] ST_FLUSH = 4'd12;

	localparam int MQ_W = ACC_W - T_FRAC;
	localparam int MN_W = MQ_W + STEP_W + 1;
	localparam int DN_W = COEF_W + STEP_W + 1;
	localparam int RN_W = T_FRAC + STEP_W;
	localparam logic signed [ACC_W-1:0] ONE_ACC = ACC_W'(1) <<< T_FRAC;
	localparam logic [STEP_W:0] ONE_T = (STEP_W+1)'(1) << T_FRAC;

	logic [3:0]               st_q;
	cmd_t                     cmd_q;
	logic [STEP_W-1:0]        n_q;
	logic [SEG_CNT_W-1:0]     k_q;
	logic signed [ACC_W-1:0]  acc_q [2];
	coord_t                   hist0_q [2];
	coord_t                   hist1_q [2];
	logic [1:0]               held_q;
	coord_t                   cen_q [2];
	logic signed [MAG_W-1:0]  dif_q [2];
	logic                     tail_q;
	logic                     splast_q;
	logic                     nz_q;
	logic [L2_W-1:0]          l2_q;
	logic [Q_W-1:0]           qn_q [2];
	logic [Q2_W-1:0]          q2_q [2];
	logic signed [P_W-1:0]    p_q [2];
	logic signed [P_W-1:0]    r_q [2];
	logic [KW-1:0]            kk_q [2];
	logic [KBIT_W-1:0]        bit_q;
	logic [DATA_W-1:0]        res_q;
	logic                     pend_v_q;
	logic [DATA_W-1:0]        pend_d_q;
	logic                     pend_u_q;
	logic                     out_v_q;
	logic [DATA_W-1:0]        out_d_q;
	logic                     out_l_q;
	logic                     out_u_q;

	logic signed [ACC_W-1:0]  qsh [2];
	logic signed [MN_W-1:0]   qn_m [2];
	logic [RN_W-1:0]          rn_m [2];
	logic signed [ACC_W-1:0]  mt [2];
	logic signed [DN_W-1:0]   dn [2];
	logic signed [ACC_W-1:0]  rnd [2];
	coord_t                   sv [2];
	coord_t                   base [2];
	logic [MAG_W-1:0]         mag [2];
	logic signed [P_W-1:0]    pc [2];
	logic signed [P_W-1:0]    r_nx [2];
	logic                     take [2];
	logic [STEP_W:0]          n_next;
	logic [THICK_W-1:0]       h2;
	logic signed [KW+1:0]     ox;
	logic signed [KW+1:0]     oy;
	logic [DATA_W-1:0]        res_d;
	logic                     out_free;
	logic                     out_load;

	assign q_pop       = (st_q == ST_IDLE) && !q_empty;
	assign out_valid   = out_v_q;
	assign out_data    = out_d_q;
	assign out_last    = out_l_q;
	assign out_user    = out_u_q;
	assign stat.busy   = (st_q != ST_IDLE);
	assign stat.pend_v = pend_v_q;
	assign out_free    = !out_v_q || out_ready;
	assign out_load    = ((st_q == ST_PUT) || (st_q == ST_FLUSH)) && pend_v_q && out_free;
	assign n_next      = {1'b0, n_q} + {1'b0, step};
	assign h2          = (thick < THICK_MIN) ? THICK_MIN : thick;

	// Horner steps, sample rounding, history difference and search step per lane.
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			qsh[l]  = acc_q[l] >>> T_FRAC;
			qn_m[l] = $signed(qsh[l][MQ_W-1:0]) * $signed({1'b0, n_q});
			rn_m[l] = acc_q[l][T_FRAC-1:0] * n_q;
			mt[l]   = ACC_W'(qn_m[l]) + ACC_W'(rn_m[l][RN_W-1:T_FRAC]);
			dn[l]   = $signed(cmd_q.cd[l]) * $signed({1'b0, n_q});
			rnd[l]  = (acc_q[l] + ONE_ACC) >>> (T_FRAC + 1);
			sv[l]   = sat_coord(rnd[l][SAT_W-1:0]);
			base[l] = (held_q == 2'd1) ? hist1_q[l] : hist0_q[l];
			mag[l]  = dif_q[l][MAG_W-1] ? MAG_W'(-dif_q[l]) : MAG_W'(dif_q[l]);
			pc[l]   = p_q[l] + (r_q[l] <<< (bit_q + 2))
				+ $signed(P_W'(l2_q) << (2 * bit_q + 2));
			r_nx[l] = r_q[l] + $signed(P_W'(l2_q) << (bit_q + 1));
			take[l] = (pc[l] <= $signed(P_W'(q2_q[l])));
		end
	end

	// Offsets along the normal and the saturated vertex pair.
	always_comb begin
		ox = '0;
		oy = '0;
		if (nz_q) begin
			ox = (dif_q[1] > 0) ? -$signed({2'b00, kk_q[0]}) : $signed({2'b00, kk_q[0]});
			oy = (dif_q[0] < 0) ? -$signed({2'b00, kk_q[1]}) : $signed({2'b00, kk_q[1]});
		end
		res_d = {sat_coord(SAT_W'(cen_q[1]) - SAT_W'(oy)),
			sat_coord(SAT_W'(cen_q[0]) - SAT_W'(ox)),
			sat_coord(SAT_W'(cen_q[1]) + SAT_W'(oy)),
			sat_coord(SAT_W'(cen_q[0]) + SAT_W'(ox))};
	end

	// Sequencer, history count and handshake flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			held_q   <= 2'd0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (!q_empty) begin
						st_q <= q_cmd.seg ? ST_C0 : ST_TAIL;
					end
				end
				ST_C0: st_q <= ST_C1;
				ST_C1: st_q <= ST_C2;
				ST_C2: st_q <= ST_C3;
				ST_C3: begin
					if (held_q == 2'd0) begin
						held_q <= 2'd1;
						st_q   <= ST_ADV;
					end else begin
						held_q <= 2'd2;
						st_q   <= ST_SQ;
					end
				end
				ST_ADV: begin
					if (k_q < SEG_CNT_W'(MAX_SEG - 1) && n_next <= ONE_T) begin
						st_q <= ST_C0;
					end else begin
						st_q <= ST_TAIL;
					end
				end
				ST_TAIL: begin
					if (cmd_q.last) begin
						held_q <= 2'd0;
					end
					st_q <= (cmd_q.last && held_q == 2'd2) ? ST_SQ : ST_FLUSH;
				end
				ST_SQ:  st_q <= ST_SQ2;
				ST_SQ2: st_q <= ST_ITER;
				ST_ITER: begin
					if (bit_q == '0) begin
						st_q <= ST_OUTC;
					end
				end
				ST_OUTC: st_q <= ST_PUT;
				ST_PUT: begin
					if (out_free) begin
						pend_v_q <= 1'b1;
						st_q     <= tail_q ? ST_FLUSH : ST_ADV;
					end
				end
				ST_FLUSH: begin
					if (!pend_v_q) begin
						st_q <= ST_IDLE;
					end else if (out_free) begin
						pend_v_q <= 1'b0;
						st_q     <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				cmd_q <= q_cmd;
				n_q   <= '0;
				k_q   <= '0;
			end
			ST_C0: begin
				for (int l = 0; l < 2; l++) begin
					acc_q[l] <= ACC_W'(dn[l]) + (ACC_W'($signed(cmd_q.cc[l])) <<< T_FRAC);
				end
			end
			ST_C1: begin
				for (int l = 0; l < 2; l++) begin
					acc_q[l] <= mt[l] + (ACC_W'($signed(cmd_q.cb[l])) <<< T_FRAC);
				end
			end
			ST_C2: begin
				for (int l = 0; l < 2; l++) begin
					acc_q[l] <= mt[l] + (ACC_W'($signed(cmd_q.ca[l])) <<< T_FRAC);
				end
			end
			ST_C3: begin
				for (int l = 0; l < 2; l++) begin
					cen_q[l]   <= hist1_q[l];
					dif_q[l]   <= MAG_W'(sv[l]) - MAG_W'(base[l]);
					hist0_q[l] <= hist1_q[l];
					hist1_q[l] <= sv[l];
				end
				tail_q   <= 1'b0;
				splast_q <= 1'b0;
			end
			ST_ADV: begin
				n_q <= n_next[STEP_W-1:0];
				k_q <= k_q + SEG_CNT_W'(1);
			end
			ST_TAIL: begin
				for (int l = 0; l < 2; l++) begin
					cen_q[l] <= hist1_q[l];
					dif_q[l] <= MAG_W'(hist1_q[l]) - MAG_W'(hist0_q[l]);
				end
				tail_q   <= 1'b1;
				splast_q <= 1'b1;
			end
			ST_SQ: begin
				l2_q    <= L2_W'(mag[0] * mag[0]) + L2_W'(mag[1] * mag[1]);
				qn_q[0] <= Q_W'(mag[1] * h2);
				qn_q[1] <= Q_W'(mag[0] * h2);
				nz_q    <= (mag[0] != '0) || (mag[1] != '0);
			end
			ST_SQ2: begin
				for (int l = 0; l < 2; l++) begin
					q2_q[l] <= Q2_W'(qn_q[l] * qn_q[l]);
					p_q[l]  <= $signed(P_W'(l2_q));
					r_q[l]  <= -$signed(P_W'(l2_q));
					kk_q[l] <= '0;
				end
				bit_q <= KBIT_W'(KW - 1);
			end
			ST_ITER: begin
				for (int l = 0; l < 2; l++) begin
					if (take[l]) begin
						kk_q[l][bit_q] <= 1'b1;
						p_q[l]         <= pc[l];
						r_q[l]         <= r_nx[l];
					end
				end
				bit_q <= bit_q - KBIT_W'(1);
			end
			ST_OUTC: res_q <= res_d;
			ST_PUT: begin
				if (out_free) begin
					if (pend_v_q) begin
						out_d_q <= pend_d_q;
						out_l_q <= 1'b0;
						out_u_q <= pend_u_q;
					end
					pend_d_q <= res_q;
					pend_u_q <= splast_q;
				end
			end
			ST_FLUSH: begin
				if (pend_v_q && out_free) begin
					out_d_q <= pend_d_q;
					out_l_q <= 1'b1;
					out_u_q <= pend_u_q;
				end
			end
			default: ;
		endcase
	end

endmodule
